@@ rtl/assert_macros.svh @@
// Assertion helpers used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, quiet during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock, quiet during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/acr_pkg.sv @@
package acr_pkg;

	localparam int ACR_REF_POS_BITS   = 32;
	localparam int ACR_SEQ_POS_BITS   = 16;
	localparam int ACR_RUN_COUNT_BITS = 20;

	// CIGAR operation codes
	typedef enum logic [1:0] {
		OP_MATCH  = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2,
		OP_CLIP   = 2'd3
	} op_code_t;

	// Steps one pair goes through; only a final pair visits the tail and flush steps
	typedef enum logic [1:0] {
		PH_MAIN  = 2'd0,
		PH_TAIL  = 2'd1,
		PH_FLUSH = 2'd2
	} phase_t;

	// Engine status toward the input stage
	typedef struct packed {
		logic fire;  // current step executes this cycle
		logic done;  // pair in the input stage retires this cycle
	} step_ctl_t;

endpackage

@@ rtl/acr_in_stage.sv @@
module acr_in_stage
	import acr_pkg::*;
#(
	parameter int REF_POS_BITS = ACR_REF_POS_BITS,
	parameter int SEQ_POS_BITS = ACR_SEQ_POS_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [REF_POS_BITS-1:0] in_ref_pos,
	input  logic [SEQ_POS_BITS-1:0] in_seq_pos,
	input  logic [SEQ_POS_BITS-1:0] in_read_length,
	input  logic                    in_last_pair,
	input  step_ctl_t               ctl,
	output logic                    valid_s1,
	output logic [REF_POS_BITS-1:0] ref_pos_s1,
	output logic [SEQ_POS_BITS-1:0] seq_pos_s1,
	output logic [SEQ_POS_BITS-1:0] read_length_s1,
	output logic                    last_pair_s1
);

	logic accept;

	// Free when empty or when the held pair retires this cycle
	assign in_ready = !valid_s1 || ctl.done;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (ctl.done) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ref_pos_s1     <= in_ref_pos;
			seq_pos_s1     <= in_seq_pos;
			read_length_s1 <= in_read_length;
			last_pair_s1   <= in_last_pair;
		end
	end

endmodule

@@ rtl/acr_run_engine.sv @@
module acr_run_engine
	import acr_pkg::*;
#(
	parameter int REF_POS_BITS   = ACR_REF_POS_BITS,
	parameter int SEQ_POS_BITS   = ACR_SEQ_POS_BITS,
	parameter int RUN_COUNT_BITS = ACR_RUN_COUNT_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      valid_s1,
	input  logic [REF_POS_BITS-1:0]   ref_pos_s1,
	input  logic [SEQ_POS_BITS-1:0]   seq_pos_s1,
	input  logic [SEQ_POS_BITS-1:0]   read_length_s1,
	input  logic                      last_pair_s1,
	input  logic                      out_free,
	output step_ctl_t                 ctl,
	output logic                      emit,
	output op_code_t                  emit_op,
	output logic [RUN_COUNT_BITS-1:0] emit_len,
	output logic [REF_POS_BITS-1:0]   emit_start,
	output logic                      emit_last
);

	localparam int SUM_BITS =
		((RUN_COUNT_BITS > SEQ_POS_BITS) ? RUN_COUNT_BITS : SEQ_POS_BITS) + 1;
	localparam logic [SUM_BITS-1:0] RUN_MAX_EXT = SUM_BITS'({RUN_COUNT_BITS{1'b1}});

	phase_t                    phase_q, phase_d;
	logic                      first_q;
	logic [REF_POS_BITS-1:0]   start_ref_q;
	logic [REF_POS_BITS-1:0]   prev_ref_q;
	logic [SEQ_POS_BITS-1:0]   prev_seq_q;
	op_code_t                  run_op_q, nxt_op;
	logic [RUN_COUNT_BITS-1:0] run_cnt_q, nxt_cnt;

	op_code_t                  step_op;
	op_code_t                  add_op;
	logic [SEQ_POS_BITS-1:0]   add_len;
	logic [SEQ_POS_BITS-1:0]   tail_len;
	logic [RUN_COUNT_BITS-1:0] base_cnt;
	logic                      merge;
	logic [SUM_BITS-1:0]       sum;
	logic [RUN_COUNT_BITS-1:0] sat_sum;
	logic                      fire;

	// Operation implied by this pair against the previous one
	always_comb begin
		if (ref_pos_s1 != prev_ref_q) begin
			step_op = (seq_pos_s1 != prev_seq_q) ? OP_MATCH : OP_DELETE;
		end else begin
			step_op = OP_INSERT;
		end
	end

	assign tail_len = (read_length_s1 > seq_pos_s1) ? (read_length_s1 - seq_pos_s1) : '0;

	// Operation added in this step and the pending count it lands on
	always_comb begin
		add_op   = OP_CLIP;
		add_len  = '0;
		base_cnt = run_cnt_q;
		unique case (phase_q)
			PH_MAIN: begin
				if (first_q) begin
					add_op   = OP_CLIP;
					add_len  = seq_pos_s1;
					base_cnt = '0;
				end else begin
					add_op   = step_op;
					add_len  = SEQ_POS_BITS'(1);
				end
			end
			PH_TAIL: begin
				add_op  = OP_CLIP;
				add_len = tail_len;
			end
			PH_FLUSH: begin
				add_op  = OP_CLIP;
				add_len = '0;
			end
			default: begin
				add_op  = OP_CLIP;
				add_len = '0;
			end
		endcase
	end

	assign merge   = (base_cnt != '0) && (run_op_q == add_op);
	assign sum     = (merge ? SUM_BITS'(base_cnt) : '0) + SUM_BITS'(add_len);
	assign sat_sum = (sum > RUN_MAX_EXT) ? {RUN_COUNT_BITS{1'b1}} : sum[RUN_COUNT_BITS-1:0];

	// Next step
	always_comb begin
		unique case (phase_q)
			PH_MAIN:  phase_d = last_pair_s1 ? PH_TAIL : PH_MAIN;
			PH_TAIL:  phase_d = PH_FLUSH;
			PH_FLUSH: phase_d = PH_MAIN;
			default:  phase_d = PH_MAIN;
		endcase
	end

	// Emission and pending run update
	always_comb begin
		emit      = 1'b0;
		emit_op   = run_op_q;
		emit_len  = run_cnt_q;
		emit_last = 1'b0;
		nxt_op    = run_op_q;
		nxt_cnt   = base_cnt;
		unique case (phase_q)
			PH_MAIN, PH_TAIL: begin
				if (add_len == '0) begin
					nxt_cnt = base_cnt;
				end else if (merge) begin
					nxt_cnt = sat_sum;
				end else begin
					emit    = (base_cnt != '0);
					nxt_op  = add_op;
					nxt_cnt = sat_sum;
				end
			end
			PH_FLUSH: begin
				emit      = (run_cnt_q != '0);
				emit_last = 1'b1;
				nxt_op    = OP_MATCH;
				nxt_cnt   = '0;
			end
			default: begin
				nxt_cnt = run_cnt_q;
			end
		endcase
	end

	assign fire       = valid_s1 && (!emit || out_free);
	assign ctl.fire   = fire;
	assign ctl.done   = fire && (((phase_q == PH_MAIN) && !last_pair_s1) || (phase_q == PH_FLUSH));
	assign emit_start = start_ref_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_MAIN;
			first_q     <= 1'b1;
			start_ref_q <= '0;
			prev_ref_q  <= '0;
			prev_seq_q  <= '0;
			run_op_q    <= OP_MATCH;
			run_cnt_q   <= '0;
		end else if (fire) begin
			phase_q   <= phase_d;
			run_op_q  <= nxt_op;
			run_cnt_q <= nxt_cnt;
			if (phase_q == PH_MAIN) begin
				prev_ref_q <= ref_pos_s1;
				prev_seq_q <= seq_pos_s1;
				if (first_q) begin
					start_ref_q <= ref_pos_s1;
					first_q     <= 1'b0;
				end
			end
			if (phase_q == PH_FLUSH) begin
				first_q <= 1'b1;
			end
		end
	end

endmodule

@@ rtl/acr_out_stage.sv @@
module acr_out_stage
	import acr_pkg::*;
#(
	parameter int REF_POS_BITS   = ACR_REF_POS_BITS,
	parameter int RUN_COUNT_BITS = ACR_RUN_COUNT_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  op_code_t                  emit_op,
	input  logic [RUN_COUNT_BITS-1:0] emit_len,
	input  logic [REF_POS_BITS-1:0]   emit_start,
	input  logic                      emit_last,
	input  logic                      out_ready,
	output logic                      out_free,
	output logic                      out_valid_q,
	output op_code_t                  op_code_q,
	output logic [RUN_COUNT_BITS-1:0] run_length_q,
	output logic [REF_POS_BITS-1:0]   start_ref_q,
	output logic                      last_run_q
);

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			op_code_q    <= emit_op;
			run_length_q <= emit_len;
			start_ref_q  <= emit_start;
			last_run_q   <= emit_last;
		end
	end

endmodule

@@ rtl/alignment_to_cigar_runs_unit.sv @@
// A run that a pair closes is loaded into the result register and shows on m_tvalid.
// Throughput: one pair per cycle while the engine is not held; a pair marked tlast
// occupies the run engine for its main, trailing clip and flush steps in turn;
// one output run per cycle at most, and m_tready low holds the engine on a new run.
// Reset: arst_n low clears both valid flags and the run state; the next pair
// starts a new alignment.
module alignment_to_cigar_runs_unit
	import acr_pkg::*;
#(
	parameter int REF_POS_BITS   = ACR_REF_POS_BITS,
	parameter int SEQ_POS_BITS   = ACR_SEQ_POS_BITS,
	parameter int RUN_COUNT_BITS = ACR_RUN_COUNT_BITS
) (
	input  logic clk,
	input  logic arst_n,
	// Aligned pair stream; tlast marks the final pair of an alignment
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// ref_pos, seq_pos, read_length
	input  logic [((REF_POS_BITS + 2 * SEQ_POS_BITS + 7) / 8) * 8-1:0] s_tdata,
	input  logic                         s_tlast,
	// CIGAR run stream; tlast marks the final run of an alignment
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// run_length, start_ref
	output logic [((RUN_COUNT_BITS + REF_POS_BITS + 7) / 8) * 8-1:0] m_tdata,
	output logic [1:0]                   m_tuser,  // op_code
	output logic                         m_tlast
);

	// Stream buses carry whole bytes
	localparam int OUT_TDATA_BITS = ((RUN_COUNT_BITS + REF_POS_BITS + 7) / 8) * 8;

	step_ctl_t                 ctl;
	logic                      valid_s1;
	logic [REF_POS_BITS-1:0]   ref_pos_s1;
	logic [SEQ_POS_BITS-1:0]   seq_pos_s1;
	logic [SEQ_POS_BITS-1:0]   read_length_s1;
	logic                      last_pair_s1;

	logic                      emit;
	op_code_t                  emit_op;
	logic [RUN_COUNT_BITS-1:0] emit_len;
	logic [REF_POS_BITS-1:0]   emit_start;
	logic                      emit_last;
	logic                      out_free;

	op_code_t                  op_code_q;
	logic [RUN_COUNT_BITS-1:0] run_length_q;
	logic [REF_POS_BITS-1:0]   start_ref_q;

	// Input register: hold one pair until the engine has finished all its steps
	acr_in_stage #(
		.REF_POS_BITS (REF_POS_BITS),
		.SEQ_POS_BITS (SEQ_POS_BITS)
	) u_in_stage (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.in_ref_pos     (s_tdata[REF_POS_BITS-1:0]),
		.in_seq_pos     (s_tdata[REF_POS_BITS+SEQ_POS_BITS-1:REF_POS_BITS]),
		.in_read_length (s_tdata[REF_POS_BITS+2*SEQ_POS_BITS-1:REF_POS_BITS+SEQ_POS_BITS]),
		.in_last_pair   (s_tlast),
		.ctl            (ctl),
		.valid_s1       (valid_s1),
		.ref_pos_s1     (ref_pos_s1),
		.seq_pos_s1     (seq_pos_s1),
		.read_length_s1 (read_length_s1),
		.last_pair_s1   (last_pair_s1)
	);

	// Run engine: classify the pair, merge into the pending run, emit on a change or flush
	acr_run_engine #(
		.REF_POS_BITS   (REF_POS_BITS),
		.SEQ_POS_BITS   (SEQ_POS_BITS),
		.RUN_COUNT_BITS (RUN_COUNT_BITS)
	) u_run_engine (
		.clk            (clk),
		.arst_n         (arst_n),
		.valid_s1       (valid_s1),
		.ref_pos_s1     (ref_pos_s1),
		.seq_pos_s1     (seq_pos_s1),
		.read_length_s1 (read_length_s1),
		.last_pair_s1   (last_pair_s1),
		.out_free       (out_free),
		.ctl            (ctl),
		.emit           (emit),
		.emit_op        (emit_op),
		.emit_len       (emit_len),
		.emit_start     (emit_start),
		.emit_last      (emit_last)
	);

	// Result register: a finished run waits here while the next pair advances
	acr_out_stage #(
		.REF_POS_BITS   (REF_POS_BITS),
		.RUN_COUNT_BITS (RUN_COUNT_BITS)
	) u_out_stage (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (ctl.fire && emit),
		.emit_op      (emit_op),
		.emit_len     (emit_len),
		.emit_start   (emit_start),
		.emit_last    (emit_last),
		.out_ready    (m_tready),
		.out_free     (out_free),
		.out_valid_q  (m_tvalid),
		.op_code_q    (op_code_q),
		.run_length_q (run_length_q),
		.start_ref_q  (start_ref_q),
		.last_run_q   (m_tlast)
	);

	// Pack the result transaction, padding up to whole bytes with zeros
	assign m_tdata = OUT_TDATA_BITS'({start_ref_q, run_length_q});
	assign m_tuser = op_code_q;

endmodule

@@ rtl/acr_port_checker.sv @@
`include "assert_macros.svh"

module acr_port_checker
	import acr_pkg::*;
#(
	parameter int REF_POS_BITS   = ACR_REF_POS_BITS,
	parameter int SEQ_POS_BITS   = ACR_SEQ_POS_BITS,
	parameter int RUN_COUNT_BITS = ACR_RUN_COUNT_BITS
) (
	input logic                                                 clk,
	input logic                                                 arst_n,
	input logic                                                 s_tvalid,
	input logic                                                 s_tready,
	input logic [((REF_POS_BITS+2*SEQ_POS_BITS+7)/8)*8-1:0]     s_tdata,
	input logic                                                 s_tlast,
	input logic                                                 m_tvalid,
	input logic                                                 m_tready,
	input logic [((RUN_COUNT_BITS+REF_POS_BITS+7)/8)*8-1:0]     m_tdata,
	input logic [1:0]                                           m_tuser,
	input logic                                                 m_tlast
);

	logic                    out_stall;
	logic                    out_mid_run;
	logic [REF_POS_BITS-1:0] out_start;
	logic                    in_stall;

	assign out_stall   = m_tvalid && !m_tready;
	assign out_mid_run = m_tvalid && m_tready && !m_tlast;
	assign out_start   = m_tdata[RUN_COUNT_BITS+REF_POS_BITS-1:RUN_COUNT_BITS];
	assign in_stall    = s_tvalid && !s_tready;

	// A waiting run holds its transaction
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
		"output transaction changed while stalled")

	// Runs are never empty
	`ASSERT_IMPL(a_run_nonzero, clk, arst_n, m_tvalid,
		m_tdata[RUN_COUNT_BITS-1:0] != '0, "run of length zero")

	// Runs of one alignment share the start position
	`ASSERT_NEXT(a_same_start, clk, arst_n, out_mid_run,
		!m_tvalid || (out_start == $past(out_start)),
		"start position changed inside an alignment")

	// A waiting pair holds its transaction
	`ASSERT_NEXT(a_in_hold, clk, arst_n, in_stall,
		s_tvalid && $stable(s_tdata) && $stable(s_tlast),
		"input transaction changed while stalled")

endmodule

bind alignment_to_cigar_runs_unit acr_port_checker #(
	.REF_POS_BITS   (REF_POS_BITS),
	.SEQ_POS_BITS   (SEQ_POS_BITS),
	.RUN_COUNT_BITS (RUN_COUNT_BITS)
) u_acr_port_checker (.*);
